// ----- rtl/gn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants, types and helper functions for the 2D gradient noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 10;

  // Corner hash multipliers
  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  // Gradient CORDIC: Q30 datapath, phase in 2^-32 turn units
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 34;
  localparam int PHASE_W      = 32;
  localparam int GRAD_W       = 16;
  localparam int GRAD_SHIFT   = 15;
  // two rotations per register stage, plus one round/quadrant stage
  localparam int GRAD_LAT     = CORDIC_STEPS / 2 + 1;

  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032875;
  localparam logic signed [CORDIC_W-1:0] CORDIC_HALF  = 34'sd1 <<< (GRAD_SHIFT - 1);
  localparam logic signed [CORDIC_W-1:0] GRAD_MAX     = 34'sd32767;

  localparam logic signed [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_e;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [PHASE_W-1:0]  z;
  } cordic_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // One CORDIC rotation step, shifts floor
  function automatic cordic_t cordic_rot(input cordic_t v, input logic [3:0] i);
    cordic_t r;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    xs = $signed(v.x) >>> i;
    ys = $signed(v.y) >>> i;
    if (!v.z[PHASE_W-1]) begin
      r.x = $signed(v.x) - ys;
      r.y = $signed(v.y) + xs;
      r.z = $signed(v.z) - ATAN_TURNS[i];
    end else begin
      r.x = $signed(v.x) + ys;
      r.y = $signed(v.y) - xs;
      r.z = $signed(v.z) + ATAN_TURNS[i];
    end
    return r;
  endfunction

  function automatic logic signed [GRAD_W-1:0] clamp_grad(
    input logic signed [CORDIC_W-1:0] v
  );
    if (v > GRAD_MAX) begin
      return GRAD_W'(GRAD_MAX);
    end else if (v < -GRAD_MAX) begin
      return GRAD_W'(-GRAD_MAX);
    end
    return GRAD_W'(v);
  endfunction

endpackage

// ----- rtl/gradient_noise_2d.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise: one signed fixed-point point in, one Q1.15 value out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries coord_x_i, coord_y_i in
//   signed Q(32-FRAC_BITS).FRAC_BITS. Output channel (out_valid_o /
//   out_stall_i) carries noise_value_o, signed Q1.15, saturated.
//   A transaction completes on a rising edge with valid high and stall low.
//   Throughput: one point per cycle on both channels while out_stall_i is low.
//   The path from input transaction to out_valid_o is: input register, three
//   hash multiply stages, nine gradient stages (CORDIC, two rotations per
//   stage, then rounding), dot product multiply and sum, then two
//   interpolation multiply/add pairs.
//   The output has a two-entry buffer; in_stall_o is registered and rises
//   only once both entries hold results, after which the whole pipeline holds.
//   Reset clears all valid bits and both output entries; data registers are
//   not reset. There is no other state, so no warm-up after reset.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
  parameter int FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] noise_value_o
);

  localparam int GW      = gn2d_pkg::GRAD_W;
  localparam int ST_GRAD = 3 + gn2d_pkg::GRAD_LAT;  // stage holding the gradients
  localparam int NSTG    = ST_GRAD + 7;
  localparam int FLEN    = ST_GRAD + 5;
  localparam int PW      = FRAC_BITS + 1 + GW;      // offset * gradient
  localparam int DW      = PW + 1;                  // dot sum
  localparam int NW      = 18;                      // corner value
  localparam int LD1     = NW + 1;
  localparam int LP1     = LD1 + FRAC_BITS + 1;
  localparam int RW      = NW + 2;                  // row value
  localparam int LD2     = RW + 1;
  localparam int LP2     = LD2 + FRAC_BITS + 1;

  localparam logic signed [DW-1:0]  DOT_HALF = DW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [LP1-1:0] LP1_HALF = LP1'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [LP2-1:0] LP2_HALF = LP2'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [LP2-1:0] OUT_MAX  = LP2'(32767);
  localparam logic signed [LP2-1:0] OUT_MIN  = -LP2'(32768);

  // Control
  logic            en;
  logic [NSTG-1:0] vld_q;
  logic            out_vld_q;
  logic            skid_vld_q;
  logic            take;

  // Datapath
  logic [31:0]            cell_x;
  logic [31:0]            cell_y;
  logic [31:0]            hx_q [2];
  logic [31:0]            hy_q [2];
  logic [FRAC_BITS-1:0]   fx_q [FLEN];
  logic [FRAC_BITS-1:0]   fy_q [FLEN];
  logic [31:0]            ha_q [2];
  logic [31:0]            hy1_q [2];
  logic [31:0]            ha2_q [2];
  logic [31:0]            hb_q [4];
  logic [31:0]            hc_d [4];
  logic [ANGLE_BITS-1:0]  idx_q [4];
  logic signed [GW-1:0]   grad_x [4];
  logic signed [GW-1:0]   grad_y [4];
  logic signed [PW-1:0]   prod_x_d [4];
  logic signed [PW-1:0]   prod_y_d [4];
  logic signed [PW-1:0]   prod_x_q [4];
  logic signed [PW-1:0]   prod_y_q [4];
  logic signed [NW-1:0]   dot_q [4];
  logic signed [NW-1:0]   base1_q [2];
  logic signed [LP1-1:0]  lp1_q [2];
  logic signed [RW-1:0]   row_q [2];
  logic signed [RW-1:0]   base2_q;
  logic signed [LP2-1:0]  lp2_q;
  logic signed [LP2-1:0]  blend;
  logic signed [15:0]     fin_d;
  logic signed [15:0]     fin_q;
  logic signed [15:0]     out_q;
  logic signed [15:0]     skid_q;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign take       = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Stage 0: cell corners (low 32 bits) and fractions
  assign cell_x = 32'(coord_x_i >>> FRAC_BITS);
  assign cell_y = 32'(coord_y_i >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hx_q[0] <= cell_x;
      hx_q[1] <= cell_x + 32'd1;
      hy_q[0] <= cell_y;
      hy_q[1] <= cell_y + 32'd1;
      fx_q[0] <= coord_x_i[FRAC_BITS-1:0];
      fy_q[0] <= coord_y_i[FRAC_BITS-1:0];
      for (int k = 1; k < FLEN; k++) begin
        fx_q[k] <= fx_q[k-1];
        fy_q[k] <= fy_q[k-1];
      end
    end
  end

  // Stages 1-3: hash rounds; corner k = 2*j + i
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        hc_d[2*j+i] = (ha2_q[i] ^ gn2d_pkg::rot16(hb_q[2*j+i])) * gn2d_pkg::HASH_MUL_C;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        ha_q[i]  <= hx_q[i] * gn2d_pkg::HASH_MUL_A;
        hy1_q[i] <= hy_q[i];
        ha2_q[i] <= ha_q[i];
      end
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          hb_q[2*j+i] <= (hy1_q[j] ^ gn2d_pkg::rot16(ha_q[i])) * gn2d_pkg::HASH_MUL_B;
        end
      end
      for (int k = 0; k < 4; k++) begin
        idx_q[k] <= hc_d[k][31 -: ANGLE_BITS];
      end
    end
  end

  // Gradient lookup, one CORDIC pipe per corner
  for (genvar k = 0; k < 4; k++) begin : g_corner
    gn2d_grad #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_grad (
      .clk_i    (clk_i),
      .en_i     (en),
      .idx_i    (idx_q[k]),
      .grad_x_o (grad_x[k]),
      .grad_y_o (grad_y[k])
    );
  end

  // Dot products with the offsets (fx - i, fy - j)
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        prod_x_d[2*j+i] = $signed({1'(i), fx_q[ST_GRAD]}) * grad_x[2*j+i];
        prod_y_d[2*j+i] = $signed({1'(j), fy_q[ST_GRAD]}) * grad_y[2*j+i];
      end
    end
  end

  // Interpolation result, saturated
  always_comb begin
    blend = LP2'(base2_q) + ((lp2_q + LP2_HALF) >>> FRAC_BITS);
    if (blend > OUT_MAX) begin
      fin_d = 16'sd32767;
    end else if (blend < OUT_MIN) begin
      fin_d = -16'sd32768;
    end else begin
      fin_d = 16'(blend);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_x_q[k] <= prod_x_d[k];
        prod_y_q[k] <= prod_y_d[k];
        dot_q[k]    <= NW'((DW'(prod_x_q[k]) + DW'(prod_y_q[k]) + DOT_HALF) >>> FRAC_BITS);
      end
      for (int r = 0; r < 2; r++) begin
        base1_q[r] <= dot_q[2*r];
        lp1_q[r]   <= (LD1'(dot_q[2*r+1]) - LD1'(dot_q[2*r]))
                      * $signed({1'b0, fx_q[ST_GRAD+2]});
        row_q[r]   <= RW'(LP1'(base1_q[r]) + ((lp1_q[r] + LP1_HALF) >>> FRAC_BITS));
      end
      base2_q <= row_q[0];
      lp2_q   <= (LD2'(row_q[1]) - LD2'(row_q[0])) * $signed({1'b0, fy_q[ST_GRAD+4]});
      fin_q   <= fin_d;
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_q[NSTG-1]) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_q[NSTG-1]) begin
      if (out_vld_q && !take) begin
        skid_q <= fin_q;
      end else begin
        out_q <= fin_q;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign noise_value_o = out_q;

endmodule

// ----- rtl/gn2d_grad.sv -----
// ----------------------------------------------------------------------------
// gn2d_grad
// Pipelined CORDIC gradient lookup: angle index in, unit gradient (Q15) out.
// ----------------------------------------------------------------------------
module gn2d_grad #(
  parameter int ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [ANGLE_BITS-1:0]                 idx_i,
  output logic signed [gn2d_pkg::GRAD_W-1:0]    grad_x_o,
  output logic signed [gn2d_pkg::GRAD_W-1:0]    grad_y_o
);

  localparam int NCS = gn2d_pkg::CORDIC_STEPS / 2;

  gn2d_pkg::cordic_t init_rot;
  gn2d_pkg::cordic_t stage_d [NCS];
  gn2d_pkg::cordic_t stage_q [NCS];
  gn2d_pkg::quad_e   quad_q  [NCS];

  logic signed [gn2d_pkg::CORDIC_W-1:0] rnd_x;
  logic signed [gn2d_pkg::CORDIC_W-1:0] rnd_y;
  logic signed [gn2d_pkg::GRAD_W-1:0]   cos_g;
  logic signed [gn2d_pkg::GRAD_W-1:0]   sin_g;
  logic signed [gn2d_pkg::GRAD_W-1:0]   grad_x_d;
  logic signed [gn2d_pkg::GRAD_W-1:0]   grad_y_d;

  // Rotation pipeline, two steps per stage
  always_comb begin
    init_rot.x = gn2d_pkg::CORDIC_START;
    init_rot.y = '0;
    // low 30 bits of the phase: index below the quadrant bits, left aligned
    init_rot.z = gn2d_pkg::PHASE_W'(idx_i[ANGLE_BITS-3:0]) << (gn2d_pkg::PHASE_W - ANGLE_BITS);
    stage_d[0] = gn2d_pkg::cordic_rot(gn2d_pkg::cordic_rot(init_rot, 4'd0), 4'd1);
    for (int s = 1; s < NCS; s++) begin
      stage_d[s] = gn2d_pkg::cordic_rot(
        gn2d_pkg::cordic_rot(stage_q[s-1], 4'(2 * s)), 4'(2 * s + 1));
    end
  end

  // Round to Q15, clamp, then map into the quadrant
  always_comb begin
    rnd_x = ($signed(stage_q[NCS-1].x) + gn2d_pkg::CORDIC_HALF) >>> gn2d_pkg::GRAD_SHIFT;
    rnd_y = ($signed(stage_q[NCS-1].y) + gn2d_pkg::CORDIC_HALF) >>> gn2d_pkg::GRAD_SHIFT;
    cos_g = gn2d_pkg::clamp_grad(rnd_x);
    sin_g = gn2d_pkg::clamp_grad(rnd_y);
    case (quad_q[NCS-1])
      gn2d_pkg::QUAD_I: begin
        grad_x_d = cos_g;
        grad_y_d = sin_g;
      end
      gn2d_pkg::QUAD_II: begin
        grad_x_d = -sin_g;
        grad_y_d = cos_g;
      end
      gn2d_pkg::QUAD_III: begin
        grad_x_d = -cos_g;
        grad_y_d = -sin_g;
      end
      default: begin
        grad_x_d = sin_g;
        grad_y_d = -cos_g;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= gn2d_pkg::quad_e'(idx_i[ANGLE_BITS-1 -: 2]);
      for (int s = 0; s < NCS; s++) begin
        stage_q[s] <= stage_d[s];
      end
      for (int s = 1; s < NCS; s++) begin
        quad_q[s] <= quad_q[s-1];
      end
      grad_x_o <= grad_x_d;
      grad_y_o <= grad_y_d;
    end
  end

endmodule

// ----- rtl/gn2d_checker.sv -----
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks on the gradient noise block's output buffering.
// ----------------------------------------------------------------------------
module gn2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] noise_value_o
);

  // A stalled result stays and keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled output transaction changed");

  // Input is held off only while a result waits at the output
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Buffer fills only behind a stalled output
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall raised without output stall");

  // Buffer drains only when the output transaction completes
  a_stall_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(out_valid_o && !out_stall_i))
    else $error("input stall released without output transaction");

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (.*);
